// File: rtl/sst_pkg.sv
// sst_pkg: shared types and constants for the sorted set table
// request and result payloads, operation codes, controller states and command/status groups
// no dependencies
package sst_pkg;

    localparam int FUNC_W  = 2;
    localparam int KEY_IN_W = 32;
    localparam int COUNT_W = 5;
    localparam int ELEM_W  = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_LIST   = 2'd3
    } t_func;

    typedef struct packed {
        t_func               func;
        logic [KEY_IN_W-1:0] key;
    } t_in_req;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] count;
        logic               full_error;
        logic [ELEM_W-1:0]  element;
        logic               element_valid;
        logic               last;
    } t_out_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC,
        ST_LIST
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic compare;
        logic exec;
        logic list_step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_func func;
        logic  out_free;
        logic  list_empty;
        logic  list_last;
    } t_status;

endpackage

// File: rtl/sst_ctrl.sv
// sst_ctrl: sequencing state machine for the sorted set table
// drives capture, compare, update and list steps of sst_datapath
// depends on sst_pkg
module sst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sst_pkg::t_status i_status,
    output sst_pkg::t_cmd    o_cmd
);

    sst_pkg::t_state r_state;
    sst_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sst_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sst_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = sst_pkg::ST_CMP;
                end
            end
            sst_pkg::ST_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = sst_pkg::ST_EXEC;
            end
            sst_pkg::ST_EXEC: begin
                if (i_status.out_free) begin
                    if (i_status.func == sst_pkg::FUNC_LIST && !i_status.list_empty) begin
                        n_state = sst_pkg::ST_LIST;
                    end else begin
                        // finish this request and take the next in the same cycle
                        o_cmd.exec = 1'b1;
                        o_in_ready = 1'b1;
                        n_state    = i_in_valid ? sst_pkg::ST_CMP : sst_pkg::ST_IDLE;
                    end
                end
            end
            sst_pkg::ST_LIST: begin
                if (i_status.out_free) begin
                    o_cmd.list_step = 1'b1;
                    if (i_status.list_last) begin
                        n_state = sst_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sst_pkg::ST_IDLE;
            end
        endcase
        o_cmd.capture = o_in_ready && i_in_valid;
    end

endmodule

// File: rtl/sst_datapath.sv
// sst_datapath: register row of sorted keys, parallel compare, shift and rotate
// plus the result register feeding the output channel
// depends on sst_pkg
module sst_datapath #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sst_pkg::t_in_req  i_in_data,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output sst_pkg::t_out_res o_out_data,
    input  sst_pkg::t_cmd     i_cmd,
    output sst_pkg::t_status  o_status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [KEY_WIDTH-1:0] r_keys [CAPACITY];
    logic [KEY_WIDTH-1:0] n_keys [CAPACITY];
    logic [KEY_WIDTH-1:0] w_ins  [CAPACITY];
    logic [KEY_WIDTH-1:0] w_rem  [CAPACITY];
    logic [KEY_WIDTH-1:0] w_rot  [CAPACITY];

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    sst_pkg::t_func       r_func;
    logic [KEY_WIDTH-1:0] r_key;
    logic [CAPACITY-1:0]  r_lt;
    logic [CAPACITY-1:0]  w_lt;
    logic [CAPACITY-1:0]  w_eq;
    logic                 r_found;
    logic [IW-1:0]        r_list_idx;
    logic                 r_out_valid;
    sst_pkg::t_out_res    r_out;

    logic w_full;
    logic w_do_insert;
    logic w_do_remove;
    logic w_list_last;
    logic w_out_free;

    // per-cell compare against the held key
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign w_lt[g] = (CW'(g) < r_count) && (r_keys[g] < r_key);
            assign w_eq[g] = (CW'(g) < r_count) && (r_keys[g] == r_key);

            if (g == 0) begin : g_first
                assign w_ins[g] = r_lt[g] ? r_keys[g] : r_key;
            end else begin : g_rest
                assign w_ins[g] = r_lt[g] ? r_keys[g] : (r_lt[g-1] ? r_key : r_keys[g-1]);
            end

            if (g < CAPACITY - 1) begin : g_shift
                assign w_rem[g] = r_lt[g] ? r_keys[g] : r_keys[g+1];
                assign w_rot[g] = (CW'(g + 1) == r_count) ? r_keys[0] : r_keys[g+1];
            end else begin : g_end
                assign w_rem[g] = r_keys[g];
                assign w_rot[g] = r_keys[0];
            end
        end
    endgenerate

    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_do_insert = (r_func == sst_pkg::FUNC_INSERT) && !r_found && !w_full;
    assign w_do_remove = (r_func == sst_pkg::FUNC_REMOVE) && r_found;
    assign w_list_last = ((CW'(r_list_idx) + CW'(1)) == r_count);
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_keys  = r_keys;
        n_count = r_count;
        if (i_cmd.exec && w_do_insert) begin
            n_keys  = w_ins;
            n_count = r_count + CW'(1);
        end else if (i_cmd.exec && w_do_remove) begin
            n_keys  = w_rem;
            n_count = r_count - CW'(1);
        end else if (i_cmd.list_step) begin
            n_keys  = w_rot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.exec || i_cmd.list_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_keys <= n_keys;
        if (i_cmd.capture) begin
            r_func     <= i_in_data.func;
            r_key      <= KEY_WIDTH'(i_in_data.key);
            r_list_idx <= '0;
        end else if (i_cmd.list_step) begin
            r_list_idx <= r_list_idx + IW'(1);
        end
        if (i_cmd.compare) begin
            r_lt    <= w_lt;
            r_found <= |w_eq;
        end
        if (i_cmd.exec) begin
            r_out.found         <= r_found && (r_func != sst_pkg::FUNC_LIST);
            r_out.count         <= (sst_pkg::COUNT_W)'(n_count);
            r_out.full_error    <= (r_func == sst_pkg::FUNC_INSERT) && !r_found && w_full;
            r_out.element       <= '0;
            r_out.element_valid <= 1'b0;
            r_out.last          <= 1'b1;
        end else if (i_cmd.list_step) begin
            r_out.found         <= 1'b0;
            r_out.count         <= (sst_pkg::COUNT_W)'(r_count);
            r_out.full_error    <= 1'b0;
            r_out.element       <= (sst_pkg::ELEM_W)'(r_keys[0]);
            r_out.element_valid <= 1'b1;
            r_out.last          <= w_list_last;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_data          = r_out;
    assign o_status.func       = r_func;
    assign o_status.out_free   = w_out_free;
    assign o_status.list_empty = (r_count == '0);
    assign o_status.list_last  = w_list_last;

    a_count_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_count))
        else $error("key count moved without an update");

    a_result_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec || i_cmd.list_step) |-> w_out_free)
        else $error("result loaded over an untaken result");

    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.list_step |-> (r_count != '0))
        else $error("list step on an empty set");

    a_dup_insert_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_func == sst_pkg::FUNC_INSERT && r_found) |=> $stable(r_count))
        else $error("insert of a held key changed the count");

endmodule

// File: rtl/sorted_set_table_core.sv
// sorted_set_table_core: top level of the sorted set table
// joins sst_ctrl and sst_datapath; depends on sst_pkg
//
// holds up to CAPACITY distinct keys of KEY_WIDTH bits in a row of registers kept in
// ascending order. insert, remove and query pass each request through a compare step,
// which checks the key against every held entry at once, and an update step, which
// shifts the row open or closed and loads the result; a following request is taken in
// the update step. list of a non-empty set emits the row head while the row rotates by
// one place, so the order is back in place after the last key; the controller then
// returns to idle, where the next request is taken. list of an empty set goes through
// the same compare and update steps and gives one result with element_valid low. a
// result waiting in the output register holds the controller in its update or list
// step, and with it the request input. keys are cut or zero extended to KEY_WIDTH bits
// on entry; count and element are cut or zero extended to the result field widths
module sorted_set_table_core #(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sst_pkg::t_in_req  i_in_data,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sst_pkg::t_out_res o_out_data
);

    // command and status between the sequencer and the key row
    sst_pkg::t_cmd    w_cmd;
    sst_pkg::t_status w_status;

    sst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sst_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule
